// ----- rtl/crfp_pkg.sv -----
// Shared constants, types and codes of the camera response frame parser.
package crfp_pkg;

    localparam int DATA_SIZE   = 512;
    localparam int NUM_CAMERAS = 4;
    localparam int CAM_IDX_W   = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

    localparam logic [7:0] CHAR_SYNC    = 8'h55;  // 'U'
    localparam logic [7:0] CHAR_IMAGE   = 8'h46;  // 'F'
    localparam logic [7:0] CHAR_END     = 8'h23;  // '#'
    localparam logic [7:0] CHAR_INFO    = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_REPLY   = 8'h43;  // 'C'
    localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_ACK_H   = 8'h48;  // 'H'
    localparam logic [7:0] CHAR_ACK_E   = 8'h45;  // 'E'
    localparam logic [7:0] CHAR_ACK_D   = 8'h44;  // 'D'
    localparam logic [7:0] CHAR_ACK_Q   = 8'h51;  // 'Q'

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_CMD    = 4'd1,
        PH_CAMID  = 4'd2,
        PH_TEXT   = 4'd3,
        PH_PID0   = 4'd4,
        PH_PID1   = 4'd5,
        PH_LEN0   = 4'd6,
        PH_LEN1   = 4'd7,
        PH_DATA   = 4'd8,
        PH_CRC0   = 4'd9,
        PH_CRC1   = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        KIND_IMAGE   = 3'd0,
        KIND_DONE    = 3'd1,
        KIND_INFO    = 3'd2,
        KIND_REPLY   = 3'd3,
        KIND_ACK     = 3'd4,
        KIND_UNKNOWN = 3'd5
    } kind_t;

    typedef enum logic {
        OP_RECEIVE     = 1'b0,
        OP_CLEAR_TABLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  camera_id;
        logic [7:0]  data_byte;
        logic [8:0]  data_index;
        logic [15:0] packet_id;
        logic [15:0] packet_len;
        logic [31:0] byte_offset;
        logic [31:0] file_size;
        logic [15:0] packet_count;
        logic        checksum_match;
    } result_t;

endpackage

// ----- rtl/crfp_if.sv -----
// Channel interfaces of the camera response frame parser: input, result, configuration.
interface crfp_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface crfp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  camera_id;
    logic [7:0]  data_byte;
    logic [8:0]  data_index;
    logic [15:0] packet_id;
    logic [15:0] packet_len;
    logic [31:0] byte_offset;
    logic [31:0] file_size;
    logic [15:0] packet_count;
    logic        checksum_match;

    modport source (output valid, output kind, output camera_id, output data_byte,
                    output data_index, output packet_id, output packet_len,
                    output byte_offset, output file_size, output packet_count,
                    output checksum_match, input ready);
    modport sink   (input valid, input kind, input camera_id, input data_byte,
                    input data_index, input packet_id, input packet_len,
                    input byte_offset, input file_size, input packet_count,
                    input checksum_match, output ready);
endinterface

interface crfp_cfg_if;
    logic valid;
    logic ready;
    logic receive_paused;

    modport source (output valid, output receive_paused, input ready);
    modport sink   (input valid, input receive_paused, output ready);
endinterface

// ----- rtl/crfp_core.sv -----
// Frame parser state, snapshot tables and the per-byte result logic.
module crfp_core
    import crfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  logic    paused,
    output logic    res_valid,
    output result_t res
);

    phase_t               phase_reg, phase_next;
    logic [7:0]           command_reg, command_next;
    logic [7:0]           camera_reg, camera_next;
    logic [15:0]          sum_reg, sum_next;
    logic [15:0]          pid_reg, pid_next;
    logic [15:0]          len_reg, len_next;
    logic [15:0]          count_reg, count_next;
    logic [7:0]           crc_low_reg, crc_low_next;
    logic [5:0][7:0]      info_reg, info_next;
    logic [31:0]          size_tbl_reg [NUM_CAMERAS];
    logic [31:0]          size_tbl_next [NUM_CAMERAS];
    logic [15:0]          pkt_tbl_reg [NUM_CAMERAS];
    logic [15:0]          pkt_tbl_next [NUM_CAMERAS];

    logic [7:0]           c;
    logic [15:0]          count_inc;
    logic                 cam_in_table;
    logic [CAM_IDX_W-1:0] cam_idx;
    logic [31:0]          pid_minus_one;
    logic [31:0]          offset;
    logic [31:0]          info_size;
    logic [15:0]          info_count;

    assign c             = item.rx_byte;
    assign count_inc     = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
    assign cam_in_table  = camera_reg < 8'(NUM_CAMERAS);
    assign cam_idx       = camera_reg[CAM_IDX_W-1:0];
    assign pid_minus_one = {16'd0, pid_reg} - 32'd1;
    assign offset        = 32'(pid_minus_one * 32'(DATA_SIZE));
    assign info_size     = {info_reg[3], info_reg[2], info_reg[1], info_reg[0]};
    assign info_count    = {info_reg[5], info_reg[4]};

    always_comb
    begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        camera_next   = camera_reg;
        sum_next      = sum_reg;
        pid_next      = pid_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        crc_low_next  = crc_low_reg;
        info_next     = info_reg;
        size_tbl_next = size_tbl_reg;
        pkt_tbl_next  = pkt_tbl_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.camera_id = camera_reg;

        if (step)
        begin
            if (item.op == OP_CLEAR_TABLE)
            begin
                for (int i = 0; i < NUM_CAMERAS; i++)
                begin
                    size_tbl_next[i] = '0;
                    pkt_tbl_next[i]  = '0;
                end
            end
            else if (!paused)
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (c == CHAR_SYNC)
                        begin
                            sum_next   = {8'd0, c};
                            phase_next = PH_CMD;
                        end
                    end
                    PH_CMD:
                    begin
                        sum_next     = sum_reg + {8'd0, c};
                        command_next = c;
                        count_next   = '0;
                        phase_next   = PH_CAMID;
                    end
                    PH_CAMID:
                    begin
                        sum_next    = sum_reg + {8'd0, c};
                        camera_next = c;
                        if (command_reg == CHAR_IMAGE)
                        begin
                            phase_next = PH_PID0;
                        end
                        else
                        begin
                            count_next = '0;
                            info_next  = '0;
                            phase_next = PH_TEXT;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (c == CHAR_END)
                        begin
                            phase_next = PH_HEADER;
                            if (command_reg == CHAR_INFO)
                            begin
                                if (cam_in_table)
                                begin
                                    size_tbl_next[cam_idx] = info_size;
                                    pkt_tbl_next[cam_idx]  = info_count;
                                end
                                res_valid        = 1'b1;
                                res.kind         = KIND_INFO;
                                res.file_size    = info_size;
                                res.packet_count = info_count;
                            end
                            else if (command_reg == CHAR_REPLY)
                            begin
                                res_valid     = 1'b1;
                                res.kind      = KIND_REPLY;
                                res.data_byte = camera_reg;
                            end
                            else if (command_reg == CHAR_ACK_H || command_reg == CHAR_ACK_E ||
                                     command_reg == CHAR_ACK_D || command_reg == CHAR_ACK_Q)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_ACK;
                            end
                            else if (command_reg == CHAR_UNKNOWN)
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_UNKNOWN;
                            end
                        end
                        else
                        begin
                            if (count_reg < 16'd6)
                            begin
                                info_next[count_reg[2:0]] = c;
                            end
                            count_next = count_inc;
                        end
                    end
                    PH_PID0:
                    begin
                        sum_next   = sum_reg + {8'd0, c};
                        pid_next   = {8'd0, c};
                        phase_next = PH_PID1;
                    end
                    PH_PID1:
                    begin
                        sum_next   = sum_reg + {8'd0, c};
                        pid_next   = {c, pid_reg[7:0]};
                        phase_next = PH_LEN0;
                    end
                    PH_LEN0:
                    begin
                        sum_next   = sum_reg + {8'd0, c};
                        len_next   = {8'd0, c};
                        phase_next = PH_LEN1;
                    end
                    PH_LEN1:
                    begin
                        sum_next   = sum_reg + {8'd0, c};
                        len_next   = {c, len_reg[7:0]};
                        count_next = '0;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        // keep bytes that fit the packet buffer, drop the rest silently
                        if ({16'd0, count_reg} < 32'(DATA_SIZE))
                        begin
                            sum_next       = sum_reg + {8'd0, c};
                            res_valid      = 1'b1;
                            res.kind       = KIND_IMAGE;
                            res.data_byte  = c;
                            res.data_index = count_reg[8:0];
                            res.packet_id  = pid_reg;
                        end
                        count_next = count_inc;
                        if (count_inc >= len_reg)
                        begin
                            phase_next = PH_CRC0;
                        end
                    end
                    PH_CRC0:
                    begin
                        crc_low_next = c;
                        phase_next   = PH_CRC1;
                    end
                    PH_CRC1:
                    begin
                        res_valid          = 1'b1;
                        res.kind           = KIND_DONE;
                        res.packet_id      = pid_reg;
                        res.packet_len     = count_reg;
                        res.byte_offset    = offset;
                        if (cam_in_table)
                        begin
                            res.file_size    = size_tbl_reg[cam_idx];
                            res.packet_count = pkt_tbl_reg[cam_idx];
                        end
                        res.checksum_match = (sum_reg == {c, crc_low_reg});
                        sum_next           = '0;
                        phase_next         = PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            command_reg <= '0;
            camera_reg  <= '0;
            sum_reg     <= '0;
            pid_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            crc_low_reg <= '0;
            info_reg    <= '0;
            for (int i = 0; i < NUM_CAMERAS; i++)
            begin
                size_tbl_reg[i] <= '0;
                pkt_tbl_reg[i]  <= '0;
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            command_reg  <= command_next;
            camera_reg   <= camera_next;
            sum_reg      <= sum_next;
            pid_reg      <= pid_next;
            len_reg      <= len_next;
            count_reg    <= count_next;
            crc_low_reg  <= crc_low_next;
            info_reg     <= info_next;
            size_tbl_reg <= size_tbl_next;
            pkt_tbl_reg  <= pkt_tbl_next;
        end
    end

endmodule

// ----- rtl/camera_response_frame_parser.sv -----
// Top level of the camera response frame parser: channel registers around the parser core.
//
// Usage:
//  - item channel: one beat per received camera byte (op receive) or a table clear
//    (op clear). A beat is taken at a rising edge with valid and ready both high.
//  - result channel: at most one beat per item: image byte, packet done, snapshot
//    info, reply byte, acknowledge or unknown event. Items that yield nothing
//    simply vanish inside the block.
//  - cfg channel: receive_paused, always ready. While set, received bytes are
//    dropped with no state change; clears still act. Write it only while idle.
//  - A result beat passes the input register and then the result register after its
//    item is taken. Throughput: one item per cycle while the result channel is not
//    stalled, set by the combinational parser update between the two registers.
//  - Stall: when the result register is full and not taken, the input register
//    holds its beat and ready drops once it is full too; nothing is lost.
//  - Reset (rst_n low, asynchronous): parser waits for a sync byte, all frame
//    state and both snapshot tables are zero, receive_paused is clear and both
//    channel registers are empty.
module camera_response_frame_parser
    import crfp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    crfp_item_if.sink     item,
    crfp_result_if.source result,
    crfp_cfg_if.sink      cfg
);

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    logic    paused_reg, paused_next;

    logic    item_fire;
    logic    advance;
    logic    core_valid;
    result_t core_res;

    // move the held beat into the parser whenever the result slot is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_fire)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = core_valid;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        paused_next = paused_reg;
        if (cfg.valid && cfg.ready)
        begin
            paused_next = cfg.receive_paused;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            paused_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            paused_reg    <= paused_next;
        end
    end

    // payload registers: load on a taken beat, hold otherwise
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            in_item_reg <= '{op: op_t'(item.op), rx_byte: item.rx_byte};
        end
        if (advance && core_valid)
        begin
            out_res_reg <= core_res;
        end
    end

    crfp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .paused    (paused_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    assign result.valid          = out_valid_reg;
    assign result.kind           = out_res_reg.kind;
    assign result.camera_id      = out_res_reg.camera_id;
    assign result.data_byte      = out_res_reg.data_byte;
    assign result.data_index     = out_res_reg.data_index;
    assign result.packet_id      = out_res_reg.packet_id;
    assign result.packet_len     = out_res_reg.packet_len;
    assign result.byte_offset    = out_res_reg.byte_offset;
    assign result.file_size      = out_res_reg.file_size;
    assign result.packet_count   = out_res_reg.packet_count;
    assign result.checksum_match = out_res_reg.checksum_match;

`ifndef ASSERT_OFF
    // a held input beat that does not advance means the result slot is blocked
    a_hold_only_when_blocked : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> out_valid_reg && !result.ready)
        else $error("input beat held while result slot free");

    // a blocked result slot keeps its beat to the next edge
    a_result_kept : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_res_reg))
        else $error("stalled result beat changed or dropped");

    // checksum flag belongs to packet done only
    a_checksum_kind : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_DONE |-> !result.checksum_match)
        else $error("checksum flag set outside packet done");

    // packet id appears only on image byte and packet done
    a_pid_kind : assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind != KIND_IMAGE && result.kind != KIND_DONE
        |-> result.packet_id == 16'd0)
        else $error("packet id on a non-image result");
`endif

endmodule
